[rtl/core/vmu_pkg.sv]
// Shared widths, operation codes, payload types and helpers for the vector math unit.
package vmu_pkg;

	localparam int COMP_W    = 16;
	localparam int SCAL_W    = 25;
	localparam int FRAC_BITS = 8;
	localparam int RAD_W     = 2 * COMP_W + 2;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int NUM_W     = 2 * COMP_W - 1;
	localparam int QUO_W     = COMP_W;
	localparam int WIDE_W    = 2 * COMP_W + 2;
	localparam int SQ_N      = ROOT_W;
	localparam int DIV_N     = QUO_W;

	localparam logic [2:0] FN_MAG   = 3'd0;
	localparam logic [2:0] FN_NORM  = 3'd1;
	localparam logic [2:0] FN_DIST  = 3'd2;
	localparam logic [2:0] FN_CLAMP = 3'd3;
	localparam logic [2:0] FN_DOT   = 3'd4;
	localparam logic [2:0] FN_CROSS = 3'd5;

	typedef struct packed {
		logic [2:0][COMP_W-1:0] vec;
		logic [SCAL_W-1:0]      scalar;
		logic                   sat;
	} res_t;

	typedef struct packed {
		logic                  use_div;
		logic                  use_mag;
		logic [2:0]            neg;
		logic [2:0][NUM_W-1:0] num;
		res_t                  res;
	} side_t;

	typedef struct packed {
		side_t             side;
		logic [ROOT_W-1:0] root;
	} tail_t;

	// Divide by 2^FRAC_BITS, truncating toward zero.
	function automatic logic signed [WIDE_W-1:0] rescale(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] bias;
		bias = v[WIDE_W-1] ? ((WIDE_W'(1) <<< FRAC_BITS) - WIDE_W'(1)) : '0;
		return (v + bias) >>> FRAC_BITS;
	endfunction

endpackage

[rtl/core/vector3_math_unit.sv]
// Top level of the pipelined 3D vector math unit.
//
// Input channel s_*: one transfer carries an operation code in s_tuser and two
// signed Q8.8 vectors plus an unsigned Q8.8 clamp limit in s_tdata.
// Output channel m_*: one transfer per input with vector result, scalar
// result and the cross product saturation flag.
// Operations: magnitude, normalize, distance, clamp, dot and cross product.
// Stages in order: product stage, sum stage, 17 square root stages
// (one root bit each), 16 divider stages (one quotient bit each) and the
// output register. Every operation runs the full pipeline, so results leave
// in input order.
// Throughput is one transfer per cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_tready drops in the same cycle.
// Reset clears all valid bits; no output is shown until new data arrives.
module vector3_math_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, max_magnitude
	input  logic [2:0]   s_tuser,   // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // vec_x, vec_y, vec_z, scalar, zero fill
	output logic [0:0]   m_tuser    // saturated
);

	localparam int CW = vmu_pkg::COMP_W;
	localparam int WW = vmu_pkg::WIDE_W;

	logic adv;

	// ---------------- stage 1: products
	logic signed [CW-1:0] a_in [3];
	logic signed [CW-1:0] b_in [3];
	logic [CW-1:0]        lim_in;

	logic                 v_s1;
	logic [2:0]           func_s1;
	logic [2*CW-1:0]      asq_s1 [3];
	logic [2*CW:0]        dsq_s1 [3];
	logic signed [2*CW-1:0] dp_s1 [3];
	logic signed [2*CW-1:0] cp_s1 [6];
	logic [2*CW-1:0]      lim2_s1;
	logic [2:0][vmu_pkg::NUM_W-1:0] num_s1;
	logic [2:0]           neg_s1;
	logic [2:0][CW-1:0]   a_s1;

	logic [2*CW-1:0]      asq_c [3];
	logic [2*CW:0]        dsq_c [3];
	logic signed [2*CW-1:0] dp_c [3];
	logic signed [2*CW-1:0] cp_c [6];
	logic [2:0][vmu_pkg::NUM_W-1:0] num_c;

	always_comb begin
		logic signed [CW:0]     d;
		logic signed [2*CW+1:0] dsq;
		logic signed [2*CW-1:0] sq;
		logic [CW-1:0]          mag;
		logic [CW-1:0]          k;
		logic [2*CW-1:0]        prod;
		for (int i = 0; i < 3; i++) begin
			a_in[i] = s_tdata[i*CW +: CW];
			b_in[i] = s_tdata[(i+3)*CW +: CW];
		end
		lim_in = s_tdata[6*CW +: CW];
		k = (s_tuser == vmu_pkg::FN_NORM) ? CW'(1 << vmu_pkg::FRAC_BITS) : lim_in;
		for (int i = 0; i < 3; i++) begin
			sq       = a_in[i] * a_in[i];
			asq_c[i] = sq;
			d        = (CW+1)'(b_in[i]) - (CW+1)'(a_in[i]);
			dsq      = (2*CW+2)'(d) * (2*CW+2)'(d);
			dsq_c[i] = dsq[2*CW:0];
			dp_c[i]  = a_in[i] * b_in[i];
			mag      = a_in[i][CW-1] ? CW'(-a_in[i]) : a_in[i];
			prod     = (2*CW)'(mag) * (2*CW)'(k);
			num_c[i] = prod[vmu_pkg::NUM_W-1:0];
		end
		cp_c[0] = a_in[1] * b_in[2];
		cp_c[1] = a_in[2] * b_in[1];
		cp_c[2] = a_in[2] * b_in[0];
		cp_c[3] = a_in[0] * b_in[2];
		cp_c[4] = a_in[0] * b_in[1];
		cp_c[5] = a_in[1] * b_in[0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= s_tuser;
			lim2_s1 <= (2*CW)'(lim_in) * (2*CW)'(lim_in);
			num_s1  <= num_c;
			for (int i = 0; i < 3; i++) begin
				asq_s1[i] <= asq_c[i];
				dsq_s1[i] <= dsq_c[i];
				dp_s1[i]  <= dp_c[i];
				neg_s1[i] <= a_in[i][CW-1];
				a_s1[i]   <= a_in[i];
			end
			for (int i = 0; i < 6; i++) begin
				cp_s1[i] <= cp_c[i];
			end
		end
	end

	// ---------------- stage 2: sums, dot, cross, clamp test
	logic                       v_s2;
	vmu_pkg::side_t             side_s2;
	logic [vmu_pkg::RAD_W-1:0]  rad_s2;

	vmu_pkg::side_t             side_c;
	logic [vmu_pkg::RAD_W-1:0]  rad_c;

	always_comb begin
		logic [vmu_pkg::RAD_W-1:0] asum;
		logic [vmu_pkg::RAD_W-1:0] dsum;
		logic signed [WW-1:0]      dot;
		logic signed [WW-1:0]      cr;
		logic [2:0][CW-1:0]        cvec;
		logic                      clip;
		logic                      clamp_on;
		asum = vmu_pkg::RAD_W'(asq_s1[0]) + vmu_pkg::RAD_W'(asq_s1[1])
			+ vmu_pkg::RAD_W'(asq_s1[2]);
		dsum = vmu_pkg::RAD_W'(dsq_s1[0]) + vmu_pkg::RAD_W'(dsq_s1[1])
			+ vmu_pkg::RAD_W'(dsq_s1[2]);
		dot  = vmu_pkg::rescale(WW'(dp_s1[0]) + WW'(dp_s1[1]) + WW'(dp_s1[2]));
		clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			cr = vmu_pkg::rescale(WW'(cp_s1[2*i]) - WW'(cp_s1[2*i+1]));
			if (cr > WW'((1 << (CW-1)) - 1)) begin
				cvec[i] = CW'((1 << (CW-1)) - 1);
				clip    = 1'b1;
			end else if (cr < -WW'(1 << (CW-1))) begin
				cvec[i] = CW'(1 << (CW-1));
				clip    = 1'b1;
			end else begin
				cvec[i] = cr[CW-1:0];
			end
		end
		clamp_on = asum > vmu_pkg::RAD_W'(lim2_s1);

		rad_c = (func_s1 == vmu_pkg::FN_DIST) ? dsum : asum;

		side_c.neg = neg_s1;
		side_c.num = num_s1;
		side_c.use_mag = (func_s1 == vmu_pkg::FN_MAG) || (func_s1 == vmu_pkg::FN_DIST);
		side_c.use_div = ((func_s1 == vmu_pkg::FN_NORM) && (asum != '0))
			|| ((func_s1 == vmu_pkg::FN_CLAMP) && clamp_on);
		side_c.res.vec    = '0;
		side_c.res.scalar = '0;
		side_c.res.sat    = 1'b0;
		case (func_s1)
			vmu_pkg::FN_CLAMP: begin
				if (!clamp_on) begin
					side_c.res.vec = a_s1;
				end
			end
			vmu_pkg::FN_DOT: begin
				side_c.res.scalar = dot[vmu_pkg::SCAL_W-1:0];
			end
			vmu_pkg::FN_CROSS: begin
				side_c.res.vec = cvec;
				side_c.res.sat = clip;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
			rad_s2  <= rad_c;
		end
	end

	// ---------------- square root stages
	logic [vmu_pkg::ROOT_W-1:0] sq_root;
	vmu_pkg::side_t             sq_side_s3 [vmu_pkg::SQ_N];
	logic [vmu_pkg::SQ_N-1:0]   sq_v_s3;

	vmu_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (rad_s2),
		.root (sq_root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s3[0] <= side_s2;
			for (int k = 1; k < vmu_pkg::SQ_N; k++) begin
				sq_side_s3[k] <= sq_side_s3[k-1];
			end
		end
	end

	// ---------------- divider stages
	logic [2:0][vmu_pkg::QUO_W-1:0] dv_quo;
	vmu_pkg::tail_t                 dv_tail_s4 [vmu_pkg::DIV_N];
	logic [vmu_pkg::DIV_N-1:0]      dv_v_s4;

	vmu_div u_div (
		.clk (clk),
		.en  (adv),
		.num (sq_side_s3[vmu_pkg::SQ_N-1].num),
		.den (sq_root),
		.quo (dv_quo)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_tail_s4[0].side <= sq_side_s3[vmu_pkg::SQ_N-1];
			dv_tail_s4[0].root <= sq_root;
			for (int k = 1; k < vmu_pkg::DIV_N; k++) begin
				dv_tail_s4[k] <= dv_tail_s4[k-1];
			end
		end
	end

	// ---------------- output register
	vmu_pkg::res_t  out_q;
	logic           out_v_q;
	vmu_pkg::res_t  fin_c;
	vmu_pkg::tail_t last;

	always_comb begin
		last  = dv_tail_s4[vmu_pkg::DIV_N-1];
		fin_c = last.side.res;
		if (last.side.use_mag) begin
			fin_c.scalar = vmu_pkg::SCAL_W'(last.root);
		end
		if (last.side.use_div) begin
			for (int i = 0; i < 3; i++) begin
				fin_c.vec[i] = last.side.neg[i] ? CW'(-dv_quo[i]) : dv_quo[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= fin_c;
		end
	end

	// valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sq_v_s3 <= '0;
			dv_v_s4 <= '0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			sq_v_s3 <= {sq_v_s3[vmu_pkg::SQ_N-2:0], v_s2};
			dv_v_s4 <= {dv_v_s4[vmu_pkg::DIV_N-2:0], sq_v_s3[vmu_pkg::SQ_N-1]};
			out_v_q <= dv_v_s4[vmu_pkg::DIV_N-1];
		end
	end

	assign adv      = !out_v_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {(80 - 3*CW - vmu_pkg::SCAL_W)'(0), out_q.scalar, out_q.vec};
	assign m_tuser  = out_q.sat;

	// ---------------- checks
	a_sat_only_cross: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (out_q.scalar == '0))
		else $error("saturation flag on a non-cross result");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(sq_v_s3) && $stable(dv_v_s4) && $stable(v_s2)))
		else $error("pipeline moved during output stall");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(sq_v_s3[vmu_pkg::SQ_N-1] && sq_side_s3[vmu_pkg::SQ_N-1].use_div) |-> (sq_root != '0))
		else $error("divide by zero root");

endmodule

[rtl/core/vmu_isqrt.sv]
// Pipelined integer square root, one result bit per stage, rounding down.
module vmu_isqrt (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic [vmu_pkg::RAD_W-1:0]                 rad,
	output logic [vmu_pkg::ROOT_W-1:0]                root
);

	localparam int REM_W = vmu_pkg::ROOT_W + 3;

	logic [vmu_pkg::RAD_W-1:0]  rad_q  [vmu_pkg::SQ_N];
	logic [REM_W-1:0]           rem_q  [vmu_pkg::SQ_N];
	logic [vmu_pkg::ROOT_W-1:0] root_q [vmu_pkg::SQ_N];

	for (genvar k = 0; k < vmu_pkg::SQ_N; k++) begin : g_step
		logic [vmu_pkg::RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]           rem_in;
		logic [REM_W-1:0]           rem_sh;
		logic [REM_W-1:0]           trial;
		logic [vmu_pkg::ROOT_W-1:0] root_in;

		if (k == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_q[k-1];
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_sh = {rem_in[REM_W-3:0], rad_in[vmu_pkg::RAD_W-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k] <= rad_in << 2;
				if (rem_sh >= trial) begin
					rem_q[k]  <= rem_sh - trial;
					root_q[k] <= {root_in[vmu_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= rem_sh;
					root_q[k] <= {root_in[vmu_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[vmu_pkg::SQ_N-1];

endmodule

[rtl/core/vmu_div.sv]
// Pipelined three-lane unsigned restoring divider, one quotient bit per stage.
module vmu_div (
	input  logic                                clk,
	input  logic                                en,
	input  logic [2:0][vmu_pkg::NUM_W-1:0]      num,
	input  logic [vmu_pkg::ROOT_W-1:0]          den,
	output logic [2:0][vmu_pkg::QUO_W-1:0]      quo
);

	localparam int RW = vmu_pkg::ROOT_W;
	localparam int QW = vmu_pkg::QUO_W;

	logic [RW-1:0]         den_q [vmu_pkg::DIV_N];
	logic [2:0][RW-1:0]    rem_q [vmu_pkg::DIV_N];
	logic [2:0][QW-1:0]    lo_q  [vmu_pkg::DIV_N];
	logic [2:0][QW-1:0]    quo_q [vmu_pkg::DIV_N];

	for (genvar j = 0; j < vmu_pkg::DIV_N; j++) begin : g_step
		logic [RW-1:0] den_in;

		if (j == 0) begin : g_den_first
			assign den_in = den;
		end else begin : g_den_next
			assign den_in = den_q[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[j] <= den_in;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [RW-1:0] rem_in;
			logic [QW-1:0] lo_in;
			logic [QW-1:0] quo_in;
			logic [RW:0]   rem_sh;

			if (j == 0) begin : g_first
				assign rem_in = RW'(num[l][vmu_pkg::NUM_W-1:QW]);
				assign lo_in  = num[l][QW-1:0];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_q[j-1][l];
				assign lo_in  = lo_q[j-1][l];
				assign quo_in = quo_q[j-1][l];
			end

			assign rem_sh = {rem_in, lo_in[QW-1]};

			always_ff @(posedge clk) begin
				if (en) begin
					lo_q[j][l] <= lo_in << 1;
					if (rem_sh >= {1'b0, den_in}) begin
						rem_q[j][l] <= RW'(rem_sh - {1'b0, den_in});
						quo_q[j][l] <= {quo_in[QW-2:0], 1'b1};
					end else begin
						rem_q[j][l] <= rem_sh[RW-1:0];
						quo_q[j][l] <= {quo_in[QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign quo = quo_q[vmu_pkg::DIV_N-1];

endmodule
